// ===== src/tpgd_pkg.sv =====
// Shared constants and types of the touch pad gesture detector.
package tpgd_pkg;

	// Default sizing of the per-pad state.
	localparam int NUM_PADS    = 10;
	localparam int COUNT_WIDTH = 16;

	// The enable mask has one bit per physical pad.
	localparam int MASK_PADS = 10;

	// APB address width: four 32-bit registers.
	localparam int PADDR_W = 4;

	// Reset values of the configuration registers.
	localparam logic [15:0] THRESHOLD_RST  = 16'd500;
	localparam logic [15:0] DC_WINDOW_RST  = 16'd300;
	localparam logic [15:0] LONG_DELAY_RST = 16'd1000;
	localparam logic [MASK_PADS-1:0] PAD_ENABLE_RST = '0;

	// Register indexes (word address).
	typedef enum logic [1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_DC_WINDOW  = 2'd1,
		REG_LONG_DELAY = 2'd2,
		REG_PAD_ENABLE = 2'd3
	} reg_idx_t;

	// Status codes.
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_DISABLED = 1'b1;

	// One result item.
	typedef struct packed {
		logic [3:0]  pad_number;
		logic        status;
		logic        is_pressed;
		logic        press_edge;
		logic        release_edge;
		logic [15:0] edge_sample_count;
		logic        double_click;
		logic        single_click;
		logic [15:0] click_sample_count;
		logic        long_press;
		logic [31:0] long_press_elapsed_ms;
	} result_t;

endpackage

// ===== src/tpgd_sample_if.sv =====
// Input channel: one filtered touch sample per transfer.
interface tpgd_sample_if;
	logic        valid;
	logic        ready;
	logic [3:0]  pad_index;
	logic [15:0] filtered_sample;
	logic [31:0] time_ms;

	modport source (output valid, pad_index, filtered_sample, time_ms, input ready);
	modport sink   (input valid, pad_index, filtered_sample, time_ms, output ready);
endinterface

// ===== src/tpgd_result_if.sv =====
// Output channel: one gesture result per transfer.
interface tpgd_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  pad_number;
	logic        status;
	logic        is_pressed;
	logic        press_edge;
	logic        release_edge;
	logic [15:0] edge_sample_count;
	logic        double_click;
	logic        single_click;
	logic [15:0] click_sample_count;
	logic        long_press;
	logic [31:0] long_press_elapsed_ms;

	modport source (output valid, pad_number, status, is_pressed, press_edge, release_edge,
		edge_sample_count, double_click, single_click, click_sample_count, long_press,
		long_press_elapsed_ms, input ready);
	modport sink (input valid, pad_number, status, is_pressed, press_edge, release_edge,
		edge_sample_count, double_click, single_click, click_sample_count, long_press,
		long_press_elapsed_ms, output ready);
endinterface

// ===== src/tpgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpgd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// Read returns the contents before a same-cycle write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/touch_pad_gesture_detector_unit.sv =====
// Top level of the touch pad gesture detector: config registers, state RAM and update pipeline.
//
// Takes one sample transfer per clock unless the result output stalls, and returns one result
// per sample through the stage 1 and output registers. The per-pad state lives in one RAM:
// the entry is read when the sample is taken and written back when the updated sample leaves
// the update stage, so a pad may be hit in consecutive cycles; the freshly written entry is
// forwarded to the next sample of the same pad. Entries that were never written read as
// released with all counters and times zero, right out of reset, with no clearing pass.
// Configuration must be written through the APB port only while no sample is in flight, which
// the block does not enforce; a disabled pad's samples return status 1 and leave the state untouched.
module touch_pad_gesture_detector_unit #(
	parameter int NumPads    = tpgd_pkg::NUM_PADS,
	parameter int CountWidth = tpgd_pkg::COUNT_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tpgd_sample_if.sink                  sample,
	tpgd_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpgd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int AddrW = (NumPads > 1) ? $clog2(NumPads) : 1;

	// One RAM entry per pad.
	typedef struct packed {
		logic                  pressed;
		logic [CountWidth-1:0] cnt;
		logic [31:0]           click_time;
		logic                  pending;
		logic [CountWidth-1:0] saved;
		logic [31:0]           long_ref;
		logic                  armed;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	// Configuration registers.
	logic [15:0]                    threshold_q;
	logic [15:0]                    dc_window_q;
	logic [15:0]                    long_delay_q;
	logic [tpgd_pkg::MASK_PADS-1:0] pad_enable_q;
	tpgd_pkg::reg_idx_t             reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = tpgd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= tpgd_pkg::THRESHOLD_RST;
			dc_window_q  <= tpgd_pkg::DC_WINDOW_RST;
			long_delay_q <= tpgd_pkg::LONG_DELAY_RST;
			pad_enable_q <= tpgd_pkg::PAD_ENABLE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				tpgd_pkg::REG_THRESHOLD:  threshold_q  <= pwdata[15:0];
				tpgd_pkg::REG_DC_WINDOW:  dc_window_q  <= pwdata[15:0];
				tpgd_pkg::REG_LONG_DELAY: long_delay_q <= pwdata[15:0];
				tpgd_pkg::REG_PAD_ENABLE: pad_enable_q <= pwdata[tpgd_pkg::MASK_PADS-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			tpgd_pkg::REG_THRESHOLD:  prdata = 32'(threshold_q);
			tpgd_pkg::REG_DC_WINDOW:  prdata = 32'(dc_window_q);
			tpgd_pkg::REG_LONG_DELAY: prdata = 32'(long_delay_q);
			tpgd_pkg::REG_PAD_ENABLE: prdata = 32'(pad_enable_q);
			default:                  prdata = '0;
		endcase
	end

	// Pipeline control
	logic             s1_valid_q;
	logic             out_valid_q;
	logic             s1_adv;
	logic             take;
	logic             wr_en;
	logic [AddrW-1:0] in_addr;
	logic             in_enabled;

	assign s1_adv       = s1_valid_q && (!out_valid_q || result.ready);
	assign sample.ready = !s1_valid_q || s1_adv;
	assign take         = sample.valid && sample.ready;
	assign in_addr      = AddrW'(sample.pad_index);
	assign in_enabled   = (32'(sample.pad_index) < 32'(NumPads))
		&& (32'(sample.pad_index) < 32'(tpgd_pkg::MASK_PADS))
		&& pad_enable_q[sample.pad_index];

	// Stage 1 registers: sample, lookup side info and forwarded entry
	logic [3:0]       pad_s1;
	logic [15:0]      level_s1;
	logic [31:0]      time_s1;
	logic             en_s1;
	logic             fwd_s1;
	logic             rdv_s1;
	entry_t           fwd_data_s1;
	logic [AddrW-1:0] addr_s1;
	logic [NumPads-1:0] written_q;
	logic [EntryW-1:0]  rdata;
	entry_t           nxt;

	always_ff @(posedge clk) begin
		if (take) begin
			pad_s1      <= sample.pad_index;
			level_s1    <= sample.filtered_sample;
			time_s1     <= sample.time_ms;
			addr_s1     <= in_addr;
			rdv_s1      <= written_q[in_addr];
			fwd_data_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			en_s1      <= 1'b0;
			fwd_s1     <= 1'b0;
			written_q  <= '0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
				en_s1      <= in_enabled;
				fwd_s1     <= wr_en && (addr_s1 == in_addr);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (wr_en) begin
				written_q[addr_s1] <= 1'b1;
			end
		end
	end

	assign wr_en = s1_adv && en_s1;

	tpgd_ram #(
		.Width (EntryW),
		.Depth (NumPads)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (take),
		.raddr (in_addr),
		.rdata (rdata)
	);

	// Update stage: gesture rules on the current entry
	entry_t            cur;
	tpgd_pkg::result_t res;
	logic              pressed;
	logic [CountWidth-1:0] cnt_inc;
	logic [31:0]       cnt_w;
	logic [31:0]       saved_w;
	logic [31:0]       dc;
	logic [31:0]       dl;
	logic              dc_in_window;

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (rdv_s1) begin
			cur = entry_t'(rdata);
		end else begin
			cur = '0;
		end

		pressed      = level_s1 <= threshold_q;
		cnt_inc      = (cur.cnt == {CountWidth{1'b1}}) ? cur.cnt : cur.cnt + CountWidth'(1);
		cnt_w        = 32'(cnt_inc);
		saved_w      = 32'(cur.saved);
		dc           = time_s1 - cur.click_time;
		dl           = time_s1 - cur.long_ref;
		dc_in_window = dc < 32'(dc_window_q);

		nxt     = cur;
		nxt.cnt = cnt_inc;
		res     = '0;
		res.pad_number = pad_s1;

		if (!en_s1) begin
			res.status = tpgd_pkg::STATUS_DISABLED;
		end else begin
			res.status = tpgd_pkg::STATUS_OK;
			if (pressed != cur.pressed) begin
				// Press or release edge
				res.press_edge        = pressed;
				res.release_edge      = !pressed;
				res.edge_sample_count = (cnt_w > 32'hFFFF) ? 16'hFFFF : cnt_w[15:0];
				if (cur.pending && pressed && dc_in_window) begin
					res.double_click = 1'b1;
					nxt.pending      = 1'b0;
				end else begin
					if (cur.pending && !dc_in_window) begin
						res.single_click       = 1'b1;
						res.click_sample_count = (saved_w > 32'hFFFF) ? 16'hFFFF : saved_w[15:0];
						nxt.pending            = 1'b0;
					end
					if (pressed) begin
						nxt.click_time = time_s1;
						nxt.pending    = 1'b1;
						nxt.saved      = cnt_inc;
					end
				end
				if (pressed) begin
					nxt.armed    = 1'b1;
					nxt.long_ref = time_s1;
				end
				nxt.cnt     = '0;
				nxt.pressed = pressed;
			end else begin
				// Steady level: expired click and long press
				if (cur.pending && !dc_in_window) begin
					res.single_click       = 1'b1;
					res.click_sample_count = (saved_w > 32'hFFFF) ? 16'hFFFF : saved_w[15:0];
					nxt.pending            = 1'b0;
				end
				if (pressed && cur.armed && (dl >= 32'(long_delay_q))) begin
					res.long_press            = 1'b1;
					res.long_press_elapsed_ms = dl;
					nxt.long_ref              = time_s1;
				end
			end
			res.is_pressed = nxt.pressed;
		end
	end

	// Output register
	tpgd_pkg::result_t out_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.pad_number            = out_q.pad_number;
	assign result.status                = out_q.status;
	assign result.is_pressed            = out_q.is_pressed;
	assign result.press_edge            = out_q.press_edge;
	assign result.release_edge          = out_q.release_edge;
	assign result.edge_sample_count     = out_q.edge_sample_count;
	assign result.double_click          = out_q.double_click;
	assign result.single_click          = out_q.single_click;
	assign result.click_sample_count    = out_q.click_sample_count;
	assign result.long_press            = out_q.long_press;
	assign result.long_press_elapsed_ms = out_q.long_press_elapsed_ms;

endmodule

// ===== tb/sv/touch_pad_gesture_detector_unit_tb.sv =====
// Self-checking testbench of the touch pad gesture detector: directed and random sample streams.
module touch_pad_gesture_detector_unit_tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [3:0]  pad;
		logic [15:0] level;
		logic [31:0] stamp;
	} touch_sample_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [tpgd_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	tpgd_sample_if smp ();
	tpgd_result_if res ();

	touch_pad_gesture_detector_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the configuration registers
	logic [15:0]                    cfg_threshold  = tpgd_pkg::THRESHOLD_RST;
	logic [15:0]                    cfg_dc_window  = tpgd_pkg::DC_WINDOW_RST;
	logic [15:0]                    cfg_long_delay = tpgd_pkg::LONG_DELAY_RST;
	logic [tpgd_pkg::MASK_PADS-1:0] cfg_pad_enable = tpgd_pkg::PAD_ENABLE_RST;

	// Per-pad gesture state of the predictor
	logic        pad_down    [tpgd_pkg::MASK_PADS] = '{default: 1'b0};
	logic [15:0] run_count   [tpgd_pkg::MASK_PADS] = '{default: '0};
	logic [31:0] click_stamp [tpgd_pkg::MASK_PADS] = '{default: '0};
	logic        click_armed [tpgd_pkg::MASK_PADS] = '{default: 1'b0};
	logic [15:0] click_count [tpgd_pkg::MASK_PADS] = '{default: '0};
	logic [31:0] hold_ref    [tpgd_pkg::MASK_PADS] = '{default: '0};
	logic        hold_armed  [tpgd_pkg::MASK_PADS] = '{default: 1'b0};

	touch_sample_t     queued_samples[$];
	tpgd_pkg::result_t awaited_gestures[$];
	touch_sample_t     held_sample;

	int unsigned cycle_cnt    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned result_cnt   = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned useful_cnt   = 0;
	logic [31:0] stamp_ms     = '0;
	logic        calm;

	// Periodic calm stretches run with no idling on either side
	assign calm = (cycle_cnt % 1200) >= 1000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected gesture result of one sample; updates the per-pad state
	function automatic tpgd_pkg::result_t gesture_of_sample(input touch_sample_t s);
		tpgd_pkg::result_t r;
		logic [3:0]  p;
		logic        is_down;
		logic [15:0] cnt;
		logic [31:0] dc;
		logic [31:0] dl;
		r = '0;
		p = s.pad;
		r.pad_number = p;
		r.status = tpgd_pkg::STATUS_OK;
		if (int'(p) >= tpgd_pkg::NUM_PADS || int'(p) >= tpgd_pkg::MASK_PADS) begin
			r.status = tpgd_pkg::STATUS_DISABLED;
			return r;
		end
		if (!cfg_pad_enable[p]) begin
			r.status = tpgd_pkg::STATUS_DISABLED;
			return r;
		end
		is_down = s.level <= cfg_threshold;
		cnt = run_count[p];
		if (cnt != '1)
			cnt = cnt + 16'd1;
		run_count[p] = cnt;
		dc = s.stamp - click_stamp[p];
		if (is_down != pad_down[p]) begin
			r.press_edge = is_down;
			r.release_edge = !is_down;
			r.edge_sample_count = cnt;
			if (click_armed[p] && is_down && dc < 32'(cfg_dc_window)) begin
				// second press in the window consumes the pending click
				r.double_click = 1'b1;
				click_armed[p] = 1'b0;
			end else begin
				if (click_armed[p] && dc >= 32'(cfg_dc_window)) begin
					r.single_click = 1'b1;
					r.click_sample_count = click_count[p];
					click_armed[p] = 1'b0;
				end
				if (is_down) begin
					click_stamp[p] = s.stamp;
					click_armed[p] = 1'b1;
					click_count[p] = cnt;
				end
			end
			if (is_down) begin
				hold_armed[p] = 1'b1;
				hold_ref[p] = s.stamp;
			end
			run_count[p] = '0;
			pad_down[p] = is_down;
		end else begin
			dl = s.stamp - hold_ref[p];
			if (click_armed[p] && dc >= 32'(cfg_dc_window)) begin
				r.single_click = 1'b1;
				r.click_sample_count = click_count[p];
				click_armed[p] = 1'b0;
			end
			if (is_down && hold_armed[p] && dl >= 32'(cfg_long_delay)) begin
				r.long_press = 1'b1;
				r.long_press_elapsed_ms = dl;
				hold_ref[p] = s.stamp;
			end
		end
		r.is_pressed = pad_down[p];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_cnt < PRINT_LIMIT)
			$display("[%0t] result %0d: %s", $realtime, result_cnt, what);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	task automatic check_result();
		tpgd_pkg::result_t want;
		if (awaited_gestures.size() == 0) begin
			report_mismatch("result with no sample outstanding");
			return;
		end
		want = awaited_gestures.pop_front();
		check_field("pad_number", 32'(res.pad_number), 32'(want.pad_number));
		check_field("status", 32'(res.status), 32'(want.status));
		check_field("is_pressed", 32'(res.is_pressed), 32'(want.is_pressed));
		check_field("press_edge", 32'(res.press_edge), 32'(want.press_edge));
		check_field("release_edge", 32'(res.release_edge), 32'(want.release_edge));
		check_field("edge_sample_count", 32'(res.edge_sample_count),
			32'(want.edge_sample_count));
		check_field("double_click", 32'(res.double_click), 32'(want.double_click));
		check_field("single_click", 32'(res.single_click), 32'(want.single_click));
		check_field("click_sample_count", 32'(res.click_sample_count),
			32'(want.click_sample_count));
		check_field("long_press", 32'(res.long_press), 32'(want.long_press));
		check_field("long_press_elapsed_ms", res.long_press_elapsed_ms,
			want.long_press_elapsed_ms);
	endtask

	// Sample driver: predicts on each transfer, then launches the next queued sample
	always @(posedge clk) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready)
				awaited_gestures.push_back(gesture_of_sample(held_sample));
			if (!smp.valid || smp.ready) begin
				if (queued_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
					held_sample = queued_samples.pop_front();
					smp.valid <= 1'b1;
					smp.pad_index <= held_sample.pad;
					smp.filtered_sample <= held_sample.level;
					smp.time_ms <= held_sample.stamp;
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				check_result();
				result_cnt++;
			end
			res.ready <= calm || ($urandom_range(0, 99) >= 19);
		end
	end

	// Watchdog: ends the run when no transfer happens for too long
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("touch_pad_gesture_detector_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input tpgd_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		// register is written at this edge
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tpgd_pkg::REG_THRESHOLD:  cfg_threshold = value[15:0];
			tpgd_pkg::REG_DC_WINDOW:  cfg_dc_window = value[15:0];
			tpgd_pkg::REG_LONG_DELAY: cfg_long_delay = value[15:0];
			tpgd_pkg::REG_PAD_ENABLE: cfg_pad_enable = value[tpgd_pkg::MASK_PADS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] thr, input logic [15:0] win,
		input logic [15:0] hold, input logic [tpgd_pkg::MASK_PADS-1:0] mask);
		write_reg(tpgd_pkg::REG_THRESHOLD, {16'd0, thr});
		write_reg(tpgd_pkg::REG_DC_WINDOW, {16'd0, win});
		write_reg(tpgd_pkg::REG_LONG_DELAY, {16'd0, hold});
		write_reg(tpgd_pkg::REG_PAD_ENABLE, {{(32 - tpgd_pkg::MASK_PADS){1'b0}}, mask});
	endtask

	// Wait until every sample is sent and every result is back
	task automatic drain();
		while (queued_samples.size() != 0 || smp.valid || awaited_gestures.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_sample(input logic [3:0] pad, input logic [15:0] level,
		input logic [31:0] stamp);
		touch_sample_t s;
		s.pad = pad;
		s.level = level;
		s.stamp = stamp;
		queued_samples.push_back(s);
		if (int'(pad) < tpgd_pkg::MASK_PADS && cfg_pad_enable[pad])
			useful_cnt++;
	endtask

	function automatic logic [15:0] pressed_level();
		return 16'($urandom_range(0, 32'(cfg_threshold)));
	endfunction

	function automatic logic [15:0] released_level();
		if (cfg_threshold == 16'hFFFF)
			return pressed_level();
		return 16'($urandom_range(int'(cfg_threshold) + 1, 65535));
	endfunction

	// Advance the shared millisecond clock by a random step, then queue a sample
	task automatic step_sample(input logic [3:0] pad, input logic [15:0] level,
		input int unsigned max_dt);
		stamp_ms = stamp_ms + $urandom_range(0, max_dt);
		push_sample(pad, level, stamp_ms);
	endtask

	// One random gesture on one pad: tap, double tap, hold, quiet spell or noise
	task automatic add_gesture();
		logic [3:0]  pad;
		int unsigned win;
		int unsigned hold;
		int unsigned kind;
		pad = 4'($urandom_range(0, 9));
		win = 32'(cfg_dc_window);
		hold = 32'(cfg_long_delay);
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			// noise: any pad, any reading, any timestamp
			stamp_ms = $urandom;
			push_sample(4'($urandom_range(0, 15)), 16'($urandom), stamp_ms);
		end else if (kind < 40) begin
			step_sample(pad, pressed_level(), win + win / 2 + 1);
			repeat ($urandom_range(0, 3)) step_sample(pad, pressed_level(), win / 4 + 1);
			step_sample(pad, released_level(), win / 2 + 1);
			repeat ($urandom_range(0, 3)) step_sample(pad, released_level(), win / 2 + 1);
		end else if (kind < 60) begin
			repeat (2) begin
				step_sample(pad, pressed_level(), win / 2 + 1);
				step_sample(pad, released_level(), win / 2 + 1);
			end
		end else if (kind < 85) begin
			step_sample(pad, pressed_level(), win + 1);
			repeat ($urandom_range(1, 8)) step_sample(pad, pressed_level(), hold + hold / 2 + 1);
			step_sample(pad, released_level(), hold / 4 + 1);
		end else begin
			// quiet spell lets pending clicks expire
			repeat ($urandom_range(1, 4)) step_sample(pad, released_level(), 2 * win + 1);
		end
	endtask

	task automatic run_phase(input logic [15:0] thr, input logic [15:0] win,
		input logic [15:0] hold, input logic [tpgd_pkg::MASK_PADS-1:0] mask,
		input int unsigned quota);
		drain();
		set_config(thr, win, hold, mask);
		useful_cnt = 0;
		while (useful_cnt < quota)
			add_gesture();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.pad_index = '0;
		smp.filtered_sample = '0;
		smp.time_ms = '0;
		res.ready = 1'b0;
		held_sample = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Out of reset every pad is disabled
		push_sample(4'd0, 16'd0, 32'd0);
		push_sample(4'd9, 16'hFFFF, 32'hFFFF_FFFF);
		drain();

		// Directed: threshold 1000, window 300, long delay 1000, pad 8 disabled
		set_config(16'd1000, 16'd300, 16'd1000, 10'h2FF);
		// press exactly at threshold, then a double click one ms inside the window
		push_sample(4'd0, 16'd1001, 32'd1000);
		push_sample(4'd0, 16'd1000, 32'd1000);
		push_sample(4'd0, 16'd1001, 32'd1100);
		push_sample(4'd0, 16'd0, 32'd1299);
		push_sample(4'd0, 16'd1001, 32'd1350);
		push_sample(4'd0, 16'hFFFF, 32'd1400);
		// press right at the window end: delayed click on the edge, then long presses
		push_sample(4'd1, 16'd0, 32'd2000);
		push_sample(4'd1, 16'hFFFF, 32'd2100);
		push_sample(4'd1, 16'd0, 32'd2300);
		push_sample(4'd1, 16'd0, 32'd2500);
		push_sample(4'd1, 16'd0, 32'd3300);
		push_sample(4'd1, 16'd0, 32'd4299);
		push_sample(4'd1, 16'd0, 32'd5500);
		push_sample(4'd1, 16'hFFFF, 32'd5600);
		// double click and long press across the timestamp wrap
		push_sample(4'd2, 16'd0, 32'hFFFF_FF00);
		push_sample(4'd2, 16'd5000, 32'hFFFF_FF80);
		push_sample(4'd2, 16'd0, 32'h0000_0020);
		push_sample(4'd2, 16'd0, 32'h0000_0400);
		push_sample(4'd2, 16'd0, 32'h0000_0500);
		push_sample(4'd2, 16'd5000, 32'h0000_0600);
		// disabled by mask, and pad indexes past the last pad
		push_sample(4'd8, 16'd0, 32'h0000_0700);
		push_sample(4'd10, 16'd0, 32'h0000_0700);
		push_sample(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
		// delayed click reported on a release edge
		push_sample(4'd3, 16'd0, 32'd10000);
		push_sample(4'd3, 16'hFFFF, 32'd10400);
		drain();

		// Random phases over several settings
		run_phase(16'd500, 16'd300, 16'd1000, 10'h3FF, 280);
		run_phase(16'd0, 16'd0, 16'd0, 10'h155, 180);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 180);
		run_phase(16'd30000, 16'd40, 16'd150, 10'h2AA, 210);
		run_phase(16'd1200, 16'd700, 16'd3000, 10'h3FF, 210);
		run_phase(16'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 5000)),
			10'($urandom) | 10'h001, 210);

		drain();
		repeat (16) @(posedge clk);
		if (awaited_gestures.size() != 0)
			report_mismatch("results still outstanding at the end");
		if (mismatch_cnt == 0)
			$display("touch_pad_gesture_detector_unit regression: pass");
		else
			$display("touch_pad_gesture_detector_unit regression: fail");
		$finish;
	end

endmodule
